/* hdl/staggered_servo_pulse_generator_top_assert.svh */
// Assertion macros for the servo pulse generator
`ifndef STAGGERED_SERVO_PULSE_GENERATOR_TOP_ASSERT_SVH
`define STAGGERED_SERVO_PULSE_GENERATOR_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define SSPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define SSPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/sspg_pkg.sv */
package sspg_pkg;

   // fixed field widths
   localparam int STEP_BITS     = 12;
   localparam int CHAN_WIDTH    = 32;
   localparam int CHAN_IDX_BITS = 5;
   localparam int BIT_IDX_BITS  = $clog2(STEP_BITS);
   localparam int CSR_IDX_BITS  = 2;

   // request codes
   localparam logic REQ_TICK      = 1'b0;
   localparam logic REQ_SET_WIDTH = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CYCLE_LEN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHAN_EN    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT     = 2'd3;

   // register reset values: 20 ms frame in 10 us steps
   localparam int FRAME_US = 20000;
   localparam int STEP_US  = 10;
   localparam logic [STEP_BITS-1:0]  CYCLE_LEN_RST  = STEP_BITS'(FRAME_US / STEP_US);
   localparam logic [STEP_BITS-1:0]  PHASE_STEP_RST = STEP_BITS'(250);
   localparam logic [CHAN_WIDTH-1:0] CHAN_EN_RST    = CHAN_WIDTH'(255);
   localparam logic [STEP_BITS-1:0]  MIN_FRAME      = STEP_BITS'(2);

   // shared per-lane control
   typedef struct packed {
      logic                 tick;
      logic [STEP_BITS-1:0] pos;
      logic [STEP_BITS-1:0] flen;
      logic [STEP_BITS-1:0] new_width;
      logic [STEP_BITS-1:0] start_val;
   } lane_bus_type;

   // start-step sweep status and write port
   typedef struct packed {
      logic                     busy;
      logic                     start_we;
      logic [CHAN_IDX_BITS-1:0] idx;
      logic [STEP_BITS-1:0]     val;
   } sweep_type;

endpackage

/* hdl/sspg_lane.sv */
module sspg_lane import sspg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lane_bus_type bus,
   input  logic         enable,
   input  logic         width_we,
   input  logic         start_we,
   output logic         level_next
);

   logic [STEP_BITS-1:0] width_ff, width_in;
   logic [STEP_BITS-1:0] start_ff, start_in;
   logic                 level_ff;
   logic [STEP_BITS:0]   diff;
   logic [STEP_BITS-1:0] offset;

   // offset = (pos - start) mod frame, both already below frame
   always_comb begin
      diff = {1'b0, bus.pos} - {1'b0, start_ff};
      if (diff[STEP_BITS]) begin
         offset = diff[STEP_BITS-1:0] + bus.flen;
      end else begin
         offset = diff[STEP_BITS-1:0];
      end
   end

   // clear at end of pulse, set at its start, otherwise hold
   always_comb begin
      level_next = level_ff;
      if (bus.tick && enable) begin
         if (offset >= width_ff) begin
            level_next = 1'b0;
         end
         if ((offset == '0) && (width_ff != '0)) begin
            level_next = 1'b1;
         end
      end
   end

   assign width_in = width_we ? bus.new_width : width_ff;
   assign start_in = start_we ? bus.start_val : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
         level_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         level_ff <= level_next;
      end
   end

   // start step has no reset; it is swept in after reset for enabled channels only
   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

endmodule

/* hdl/sspg_phase_seq.sv */
module sspg_phase_seq import sspg_pkg::*; #(
   parameter int CHANNELS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  kick,
   input  logic [STEP_BITS-1:0]  flen,
   input  logic [STEP_BITS-1:0]  phase,
   input  logic [CHAN_WIDTH-1:0] enable,
   output sweep_type             sweep
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;
   localparam logic [CHAN_IDX_BITS-1:0] LAST_CHAN = CHAN_IDX_BITS'(CHANNELS - 1);
   localparam logic [BIT_IDX_BITS-1:0]  TOP_BIT   = BIT_IDX_BITS'(STEP_BITS - 1);

   logic [1:0]               state_ff, state_in;
   logic [BIT_IDX_BITS-1:0]  bit_ff, bit_in;
   logic [CHAN_IDX_BITS-1:0] chan_ff, chan_in;
   logic [STEP_BITS-1:0]     rem_ff, rem_in;
   logic [STEP_BITS-1:0]     acc_ff, acc_in;
   logic [STEP_BITS:0]       rem_shift, rem_red;
   logic [STEP_BITS:0]       acc_sum, acc_red;

   // one restoring-division bit per cycle: rem ends as phase mod frame
   always_comb begin
      rem_shift = {rem_ff, phase[bit_ff]};
      rem_red   = (rem_shift >= {1'b0, flen}) ? rem_shift - {1'b0, flen} : rem_shift;
      acc_sum   = {1'b0, acc_ff} + {1'b0, rem_ff};
      acc_red   = (acc_sum >= {1'b0, flen}) ? acc_sum - {1'b0, flen} : acc_sum;
   end

   // sequencer: divide, then walk channels handing out start steps by rank
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      chan_in  = chan_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      case (state_ff)
         ST_DIV: begin
            rem_in = rem_red[STEP_BITS-1:0];
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_WALK;
               chan_in  = '0;
               acc_in   = '0;
            end
         end
         ST_WALK: begin
            if (enable[chan_ff]) begin
               acc_in = acc_red[STEP_BITS-1:0];
            end
            chan_in = chan_ff + 1'b1;
            if (chan_ff == LAST_CHAN) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (kick) begin
         state_in = ST_DIV;
         bit_in   = TOP_BIT;
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DIV;
         bit_ff   <= TOP_BIT;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      acc_ff  <= acc_in;
   end

   assign sweep.busy     = (state_ff != ST_IDLE);
   assign sweep.start_we = (state_ff == ST_WALK) && enable[chan_ff];
   assign sweep.idx      = chan_ff;
   assign sweep.val      = acc_ff;

endmodule

/* hdl/staggered_servo_pulse_generator_top.sv */
// channel  direction  beat carries
// req_     in         req_type, req_channel, req_width
// rsp_     out        rsp_pin_levels, rsp_position, rsp_clamped
// csr_     in         csr_index, csr_data (register write)
//
// One beat per cycle while req_ready is high; its response is registered next cycle.
// All channel lanes evaluate in parallel, one subtract/add and compare per lane.
// After reset, and after a write to cycle_len, phase_step or channel_enable, the
// start-step sequencer divides, then walks the channels, with req_ready low.
// A stalled response holds; a new request is taken as the response is taken.
module staggered_servo_pulse_generator_top import sspg_pkg::*; #(
   parameter int CHANNELS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [CHAN_IDX_BITS-1:0] req_channel,
   input  logic [STEP_BITS-1:0]     req_width,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CHAN_WIDTH-1:0]    rsp_pin_levels,
   output logic [STEP_BITS-1:0]     rsp_position,
   output logic                     rsp_clamped,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CHAN_WIDTH-1:0]    csr_data
);

`include "staggered_servo_pulse_generator_top_assert.svh"

   logic [STEP_BITS-1:0]  cycle_len_ff, phase_step_ff;
   logic [CHAN_WIDTH-1:0] chan_en_ff;
   logic                  invert_ff;
   logic [STEP_BITS-1:0]  pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAN_WIDTH-1:0] rsp_pin_levels_ff;
   logic [STEP_BITS-1:0]  rsp_position_ff;
   logic                  rsp_clamped_ff;

   logic                  csr_we, kick, accept, tick, set_width;
   logic [STEP_BITS-1:0]  flen, pos_eff;
   logic [STEP_BITS:0]    pos_inc;
   logic [STEP_BITS-1:0]  width_sat;
   logic                  clamp;
   logic [CHANNELS-1:0]   en_lanes, level_next, vis_levels;
   logic [CHAN_WIDTH-1:0] en_ext;
   lane_bus_type          lane_bus;
   sweep_type             sweep;

   // configuration writes
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign kick      = csr_we && (csr_index != CSR_INVERT);

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_len_ff  <= CYCLE_LEN_RST;
         phase_step_ff <= PHASE_STEP_RST;
         chan_en_ff    <= CHAN_EN_RST;
         invert_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CYCLE_LEN:  cycle_len_ff  <= csr_data[STEP_BITS-1:0];
            CSR_PHASE_STEP: phase_step_ff <= csr_data[STEP_BITS-1:0];
            CSR_CHAN_EN:    chan_en_ff    <= csr_data;
            CSR_INVERT:     invert_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // frame length with a floor of two steps
   assign flen = (cycle_len_ff < MIN_FRAME) ? MIN_FRAME : cycle_len_ff;

   // start steps by rank among enabled channels
   sspg_phase_seq #(
      .CHANNELS (CHANNELS)
   ) u_phase_seq (
      .clock  (clock),
      .reset  (reset),
      .kick   (kick),
      .flen   (flen),
      .phase  (phase_step_ff),
      .enable (chan_en_ff),
      .sweep  (sweep)
   );

   // request handshake: output register frees as it is taken
   assign req_ready = !sweep.busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign tick      = accept && (req_type == REQ_TICK);
   assign set_width = accept && (req_type == REQ_SET_WIDTH);

   // step counter: restart if past a shortened frame, then advance
   always_comb begin
      pos_eff = (pos_ff >= flen) ? '0 : pos_ff;
      pos_inc = {1'b0, pos_eff} + 1'b1;
      pos_in  = pos_ff;
      if (tick) begin
         pos_in = (pos_inc >= {1'b0, flen}) ? '0 : pos_inc[STEP_BITS-1:0];
      end
   end

   // width saturation
   assign clamp     = req_width > flen;
   assign width_sat = clamp ? flen : req_width;

   assign lane_bus.tick      = tick;
   assign lane_bus.pos       = pos_eff;
   assign lane_bus.flen      = flen;
   assign lane_bus.new_width = width_sat;
   assign lane_bus.start_val = sweep.val;
   assign en_lanes           = chan_en_ff[CHANNELS-1:0];

   // channel lanes
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      sspg_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .bus        (lane_bus),
         .enable     (en_lanes[i]),
         .width_we   (set_width && (req_channel == CHAN_IDX_BITS'(i))),
         .start_we   (sweep.start_we && (sweep.idx == CHAN_IDX_BITS'(i))),
         .level_next (level_next[i])
      );
   end

   // visible levels: disabled channels read 0, enabled ones may be inverted
   assign vis_levels = (level_next & en_lanes) ^ (en_lanes & {CHANNELS{invert_ff}});
   assign en_ext     = CHAN_WIDTH'(en_lanes);

   // response register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pin_levels_ff <= CHAN_WIDTH'(vis_levels);
         rsp_position_ff   <= pos_in;
         rsp_clamped_ff    <= set_width && clamp
                              && ({1'b0, req_channel} < (CHAN_IDX_BITS + 1)'(CHANNELS));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_levels = rsp_pin_levels_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_clamped    = rsp_clamped_ff;

   // checks
   `SSPG_ASSERT_NEXT(a_tick_pos_in_frame, clock, reset, tick,
      rsp_position_ff < $past(flen), "tick position outside frame")
   `SSPG_ASSERT_NEXT(a_set_keeps_pos, clock, reset, set_width,
      rsp_position_ff == pos_ff, "set-width beat moved the step counter")
   `SSPG_ASSERT_NEXT(a_disabled_low, clock, reset, accept,
      (rsp_pin_levels_ff & ~$past(en_ext)) == '0, "disabled channel drives a level")
   `SSPG_ASSERT_SAME(a_no_req_busy, clock, reset, sweep.busy && !kick,
      !accept || !tick, "tick taken while start steps are being swept")

endmodule

/* verif/testbench.sv */
module testbench import sspg_pkg::*; ();

   localparam int NCH       = 32;
   localparam int LONG_HOLD = 300;

   // one request beat and one response beat
   typedef struct packed {
      logic                     kind;
      logic [CHAN_IDX_BITS-1:0] chan;
      logic [STEP_BITS-1:0]     wid;
   } servo_cmd_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] pins;
      logic [STEP_BITS-1:0]  pos;
      logic                  clamped;
   } servo_rsp_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   logic                     req_type    = REQ_TICK;
   logic [CHAN_IDX_BITS-1:0] req_channel = '0;
   logic [STEP_BITS-1:0]     req_width   = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   logic [CHAN_WIDTH-1:0]    rsp_pin_levels;
   logic [STEP_BITS-1:0]     rsp_position;
   logic                     rsp_clamped;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index   = CSR_CYCLE_LEN;
   logic [CHAN_WIDTH-1:0]    csr_data    = '0;

   staggered_servo_pulse_generator_top #(.CHANNELS(NCH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_channel    (req_channel),
      .req_width      (req_width),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_levels (rsp_pin_levels),
      .rsp_position   (rsp_position),
      .rsp_clamped    (rsp_clamped),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // shadow registers and servo state
   logic [STEP_BITS-1:0]  reg_cycle_len;
   logic [STEP_BITS-1:0]  reg_phase_step;
   logic [CHAN_WIDTH-1:0] reg_chan_en;
   logic                  reg_invert;
   logic [STEP_BITS-1:0]  step_pos;
   logic [STEP_BITS-1:0]  chan_width [NCH];
   logic [NCH-1:0]        chan_level;

   servo_cmd_type pending_cmds [$];
   servo_rsp_type expected_rsps [$];

   int errors       = 0;
   int ticks_sent   = 0;
   int sets_sent    = 0;
   int clamps_sent  = 0;
   int results_seen = 0;
   int settings_run = 1;
   int hold_asks    = 0;
   int hold_done    = 0;

   function automatic int frame_steps();
      return (reg_cycle_len < MIN_FRAME) ? int'(MIN_FRAME) : int'(reg_cycle_len);
   endfunction

   function automatic void servo_reset();
      reg_cycle_len  = CYCLE_LEN_RST;
      reg_phase_step = PHASE_STEP_RST;
      reg_chan_en    = CHAN_EN_RST;
      reg_invert     = 1'b0;
      step_pos       = '0;
      chan_level     = '0;
      for (int c = 0; c < NCH; c++) chan_width[c] = '0;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CHAN_WIDTH-1:0] data);
      case (idx)
         CSR_CYCLE_LEN:  reg_cycle_len  = data[STEP_BITS-1:0];
         CSR_PHASE_STEP: reg_phase_step = data[STEP_BITS-1:0];
         CSR_CHAN_EN:    reg_chan_en    = data;
         CSR_INVERT:     reg_invert     = data[0];
         default: ;
      endcase
   endfunction

   // advance the servo state by one beat and give the response it produces
   function automatic servo_rsp_type servo_predict(servo_cmd_type cmd);
      servo_rsp_type r;
      int cl, rank, start, off, w, c;
      cl        = frame_steps();
      rank      = 0;
      r.clamped = 1'b0;
      if (cmd.kind == REQ_TICK) begin
         // counter left past a shortened frame restarts
         if (int'(step_pos) >= cl) step_pos = '0;
         for (c = 0; c < NCH; c++) begin
            if (reg_chan_en[c]) begin
               start = (rank * int'(reg_phase_step)) % cl;
               rank++;
               off = (int'(step_pos) + cl - start) % cl;
               if (off >= int'(chan_width[c])) chan_level[c] = 1'b0;
               if (off == 0 && chan_width[c] != '0) chan_level[c] = 1'b1;
            end
         end
         step_pos = (int'(step_pos) + 1 >= cl) ? '0 : step_pos + 1'b1;
      end else begin
         w = int'(cmd.wid);
         if (w > cl) begin
            w         = cl;
            r.clamped = 1'b1;
         end
         chan_width[cmd.chan] = STEP_BITS'(w);
      end
      // disabled channels read 0 whatever the inversion
      r.pins = (chan_level & reg_chan_en) ^ (reg_invert ? reg_chan_en : '0);
      r.pos  = step_pos;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [CHAN_WIDTH-1:0] got,
                                logic [CHAN_WIDTH-1:0] want);
      errors++;
      $display("mismatch: %s at result %0d, got %h, expected %h",
               what, results_seen, got, want);
   endtask

   // driver: offers queued beats, predicts each one as it is taken
   servo_cmd_type cur_cmd;
   int drv_wait = 0;
   int drv_calm = 0;

   always @(posedge clock) begin : driver
      servo_rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            want = servo_predict(cur_cmd);
            expected_rsps.push_back(want);
            if (cur_cmd.kind == REQ_TICK) ticks_sent++;
            else sets_sent++;
            if (want.clamped) clamps_sent++;
            // gap before the next beat, with runs of back-to-back beats
            if (drv_calm > 0) begin
               drv_calm--;
               drv_wait = 0;
            end else begin
               if ($urandom_range(0, 31) == 0) drv_calm = 24;
               drv_wait = $urandom_range(0, 6);
            end
         end
         if (!(req_valid && !req_ready)) begin
            if (drv_wait > 0 || pending_cmds.size() == 0) begin
               req_valid <= 1'b0;
               if (drv_wait > 0) drv_wait--;
            end else begin
               cur_cmd     = pending_cmds.pop_front();
               req_type    <= cur_cmd.kind;
               req_channel <= cur_cmd.chan;
               req_width   <= cur_cmd.wid;
               req_valid   <= 1'b1;
            end
         end
      end
   end

   // monitor: checks responses in order and throttles rsp_ready
   int mon_stall = 0;
   int mon_calm  = 0;

   always @(posedge clock) begin : monitor
      servo_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               flag_mismatch("response with nothing outstanding", rsp_pin_levels, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_pin_levels !== want.pins)
                  flag_mismatch("pin_levels", rsp_pin_levels, want.pins);
               if (rsp_position !== want.pos)
                  flag_mismatch("position", CHAN_WIDTH'(rsp_position), CHAN_WIDTH'(want.pos));
               if (rsp_clamped !== want.clamped)
                  flag_mismatch("clamped", CHAN_WIDTH'(rsp_clamped), CHAN_WIDTH'(want.clamped));
            end
            results_seen++;
            if (mon_calm > 0) begin
               mon_calm--;
               mon_stall = 0;
            end else begin
               if ($urandom_range(0, 31) == 0) mon_calm = 24;
               mon_stall = $urandom_range(0, 6);
            end
         end
         // long back-pressure on request
         if (hold_asks != hold_done) begin
            hold_done++;
            mon_stall = LONG_HOLD;
         end
         if (mon_stall > 0) begin
            rsp_ready <= 1'b0;
            mon_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void queue_cmd(logic kind, logic [CHAN_IDX_BITS-1:0] ch,
                                     logic [STEP_BITS-1:0] w);
      servo_cmd_type cmd;
      cmd.kind = kind;
      cmd.chan = ch;
      cmd.wid  = w;
      pending_cmds.push_back(cmd);
   endfunction

   // mostly ticks, with width changes scattered through; a phase opens with widths
   task automatic add_random_items(int n);
      int cl, pick, top, i;
      logic [STEP_BITS-1:0] w;
      cl  = frame_steps();
      top = (cl + 1 > 4095) ? 4095 : cl + 1;
      for (i = 0; i < n; i++) begin
         if (i >= 4 && $urandom_range(0, 9) < 7) begin
            queue_cmd(REQ_TICK, CHAN_IDX_BITS'($urandom), STEP_BITS'($urandom));
         end else begin
            pick = (i < 4) ? 0 : $urandom_range(0, 9);
            if (pick < 6)      w = STEP_BITS'($urandom_range(0, top));
            else if (pick < 8) w = STEP_BITS'($urandom);
            else if (pick == 8) w = '1;
            else               w = '0;
            queue_cmd(REQ_SET_WIDTH, CHAN_IDX_BITS'($urandom), w);
         end
      end
   endtask

   task automatic reg_write(logic [CSR_IDX_BITS-1:0] idx, logic [CHAN_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic program_servo(logic [STEP_BITS-1:0] cl, logic [STEP_BITS-1:0] ps,
                                logic [CHAN_WIDTH-1:0] en, logic inv);
      reg_write(CSR_CYCLE_LEN, CHAN_WIDTH'(cl));
      reg_write(CSR_PHASE_STEP, CHAN_WIDTH'(ps));
      reg_write(CSR_CHAN_EN, en);
      reg_write(CSR_INVERT, CHAN_WIDTH'(inv));
      settings_run++;
      @(negedge clock);
   endtask

   // sender idle until every response is back, followed by idle slack
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int p, cl, nen;
      logic [CHAN_WIDTH-1:0] en;
      logic [STEP_BITS-1:0]  ps;
      servo_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default frame, saturation, zero width, disabled channel
      queue_cmd(REQ_SET_WIDTH, 5'd0, 12'd5);
      queue_cmd(REQ_SET_WIDTH, 5'd1, 12'd0);
      queue_cmd(REQ_SET_WIDTH, 5'd7, 12'hFFF);
      queue_cmd(REQ_SET_WIDTH, 5'd31, 12'd2000);
      queue_cmd(REQ_SET_WIDTH, 5'd8, 12'd2001);
      queue_cmd(REQ_SET_WIDTH, 5'd2, 12'd1);
      repeat (12) queue_cmd(REQ_TICK, 5'd0, 12'd0);
      queue_cmd(REQ_SET_WIDTH, 5'd0, 12'd2);
      repeat (3) queue_cmd(REQ_TICK, 5'h1F, 12'hFFF);
      wait_drained();

      for (p = 1; p <= 12; p++) begin
         case (p)
            // short frame below the minimum, counter past the frame, large starts
            1: program_servo(12'd0, 12'hFFF, '1, 1'b1);
            2: program_servo(12'd1, 12'd0, '0, 1'b0);
            3: program_servo(12'hFFF, 12'hFFF, '1, 1'b0);
            4: program_servo(12'd2, 12'd1, 32'h8000_0001, 1'b1);
            default: begin
               cl  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(2, 48);
               en  = ($urandom_range(0, 3) == 0) ? '1 : CHAN_WIDTH'($urandom);
               nen = $countones(en);
               if (nen == 0) nen = 1;
               ps  = $urandom_range(0, 1) ? STEP_BITS'(cl / nen) : STEP_BITS'($urandom);
               program_servo(STEP_BITS'(cl), ps, en, 1'(($urandom)));
            end
         endcase
         if (p == 6) begin
            add_random_items(70);
            hold_asks <= hold_asks + 1;
         end else if (p == 8) begin
            add_random_items(35);
            wait_drained();
            add_random_items(35);
         end else begin
            add_random_items(70);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (expected_rsps.size() != 0)
         flag_mismatch("responses never delivered", CHAN_WIDTH'(expected_rsps.size()), '0);
      $display("covered %0d ticks and %0d width writes (%0d saturated) over %0d settings",
               ticks_sent, sets_sent, clamps_sent, settings_run);
      $display("%0d responses checked, %0d mismatches", results_seen, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
